/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dsd_pkg.sv */
// ----------------------------------------------------------------------------
// dsd_pkg
// types and constants of the dle byte-stuffing deframer
// ----------------------------------------------------------------------------
package dsd_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [7:0] START_CODE_DEF  = 8'h01;
    localparam logic [7:0] END_CODE_DEF    = 8'h04;
    localparam logic [7:0] ESCAPE_CODE_DEF = 8'h10;
    localparam logic [15:0] CAPACITY_DEF = 16'hFFFF;

    localparam int ADDR_WIDTH = 4;

    typedef enum logic [1:0] {
        REG_START    = 2'd0,
        REG_END      = 2'd1,
        REG_ESCAPE   = 2'd2,
        REG_CAPACITY = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_AWAIT = 2'd0,
        PH_FRAME = 2'd1,
        PH_DROP  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_FORMAT  = 2'd2,
        KIND_OFLOW   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0]  start_code;
        logic [7:0]  end_code;
        logic [7:0]  escape_code;
        logic [15:0] payload_capacity;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_count;
    } res_t;

endpackage

/* rtl/dsd_apb_regs.sv */
// ----------------------------------------------------------------------------
// dsd_apb_regs
// apb register file holding the frame codes and the payload capacity
// ----------------------------------------------------------------------------
module dsd_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dsd_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output dsd_pkg::cfg_t                   cfg
);

    dsd_pkg::cfg_t    cfg_reg;
    dsd_pkg::cfg_t    cfg_next;
    dsd_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = dsd_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                dsd_pkg::REG_START:    cfg_next.start_code       = pwdata[7:0];
                dsd_pkg::REG_END:      cfg_next.end_code         = pwdata[7:0];
                dsd_pkg::REG_ESCAPE:   cfg_next.escape_code      = pwdata[7:0];
                dsd_pkg::REG_CAPACITY: cfg_next.payload_capacity = pwdata[15:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code       <= dsd_pkg::START_CODE_DEF;
            cfg_reg.end_code         <= dsd_pkg::END_CODE_DEF;
            cfg_reg.escape_code      <= dsd_pkg::ESCAPE_CODE_DEF;
            cfg_reg.payload_capacity <= dsd_pkg::CAPACITY_DEF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            dsd_pkg::REG_START:    prdata = {24'd0, cfg_reg.start_code};
            dsd_pkg::REG_END:      prdata = {24'd0, cfg_reg.end_code};
            dsd_pkg::REG_ESCAPE:   prdata = {24'd0, cfg_reg.escape_code};
            dsd_pkg::REG_CAPACITY: prdata = {16'd0, cfg_reg.payload_capacity};
            default:               prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/dsd_decoder.sv */
// ----------------------------------------------------------------------------
// dsd_decoder
// deframing state and the per-byte decision for one registered input byte
// ----------------------------------------------------------------------------
module dsd_decoder #(
    parameter int COUNT_WIDTH = dsd_pkg::COUNT_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    in_byte,
    input  logic          last,
    input  dsd_pkg::cfg_t cfg,
    output logic          has_result,
    output dsd_pkg::res_t res
);

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    dsd_pkg::phase_t        phase_reg;
    dsd_pkg::phase_t        phase_next;
    logic                   esc_reg;
    logic                   esc_next;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   over_cap;
    logic                   count_full;

    assign cnt_inc    = cnt_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    assign over_cap   = CMP_W'(cnt_reg) >= CMP_W'(cfg.payload_capacity);
    assign count_full = &cnt_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        esc_next         = esc_reg;
        cnt_next         = cnt_reg;
        has_result       = 1'b0;
        res.kind         = dsd_pkg::KIND_PAYLOAD;
        res.payload_byte = 8'd0;
        res.byte_count   = 16'(cnt_reg);
        case (phase_reg)
            dsd_pkg::PH_AWAIT:
            begin
                cnt_next       = '0;
                esc_next       = 1'b0;
                res.byte_count = 16'd0;
                if (in_byte != cfg.start_code || last)
                begin
                    has_result = 1'b1;
                    res.kind   = dsd_pkg::KIND_FORMAT;
                    phase_next = last ? dsd_pkg::PH_AWAIT : dsd_pkg::PH_DROP;
                end
                else
                begin
                    phase_next = dsd_pkg::PH_FRAME;
                end
            end
            dsd_pkg::PH_FRAME:
            begin
                if (!esc_reg && in_byte == cfg.escape_code)
                begin
                    if (last)
                    begin
                        has_result = 1'b1;
                        res.kind   = dsd_pkg::KIND_FORMAT;
                        phase_next = dsd_pkg::PH_AWAIT;
                        esc_next   = 1'b0;
                    end
                    else
                    begin
                        esc_next = 1'b1;
                    end
                end
                else if (!esc_reg && in_byte == cfg.end_code)
                begin
                    has_result = 1'b1;
                    res.kind   = dsd_pkg::KIND_DONE;
                    phase_next = last ? dsd_pkg::PH_AWAIT : dsd_pkg::PH_DROP;
                    esc_next   = 1'b0;
                end
                else
                begin
                    esc_next   = 1'b0;
                    has_result = 1'b1;
                    if (over_cap || count_full)
                    begin
                        res.kind   = dsd_pkg::KIND_OFLOW;
                        phase_next = last ? dsd_pkg::PH_AWAIT : dsd_pkg::PH_DROP;
                    end
                    else if (last)
                    begin
                        res.kind   = dsd_pkg::KIND_FORMAT;
                        phase_next = dsd_pkg::PH_AWAIT;
                    end
                    else
                    begin
                        cnt_next         = cnt_inc;
                        res.kind         = dsd_pkg::KIND_PAYLOAD;
                        res.payload_byte = in_byte;
                        res.byte_count   = 16'(cnt_inc);
                    end
                end
            end
            default:
            begin
                esc_next = 1'b0;
                if (last)
                begin
                    phase_next = dsd_pkg::PH_AWAIT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dsd_pkg::PH_AWAIT;
            esc_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/dsd_out_reg.sv */
// ----------------------------------------------------------------------------
// dsd_out_reg
// result register on the output channel
// ----------------------------------------------------------------------------
module dsd_out_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  dsd_pkg::res_t res,
    input  logic          out_stall,
    output logic          free,
    output logic          out_valid,
    output logic [1:0]    result_kind,
    output logic [7:0]    payload_byte,
    output logic [15:0]   byte_count
);

    logic          valid_reg;
    logic          valid_next;
    dsd_pkg::res_t res_reg;

    assign free       = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = valid_reg;
    assign result_kind  = res_reg.kind;
    assign payload_byte = res_reg.payload_byte;
    assign byte_count   = res_reg.byte_count;

endmodule

/* rtl/dle_stuffing_deframer.sv */
// ----------------------------------------------------------------------------
// dle_stuffing_deframer - dle byte-stuffing deframer
// path: a byte is held in the input register, decoded, then its result is held in the output register
// throughput: one byte per cycle unless a result meets a stalled output, set by the single decode step between regs
// reset: control cleared, codes back to soh/eot/dle, capacity 65535
// ----------------------------------------------------------------------------
module dle_stuffing_deframer #(
    parameter int COUNT_WIDTH = dsd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     in_byte,
    input  logic                           last_of_buffer,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     result_kind,
    output logic [7:0]                     payload_byte,
    output logic [15:0]                    byte_count,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dsd_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    dsd_pkg::cfg_t cfg;
    dsd_pkg::res_t res;
    logic          full_reg;
    logic          full_next;
    logic [7:0]    byte_reg;
    logic          last_reg;
    logic          accept;
    logic          move;
    logic          has_result;
    logic          out_free;

    // the input register drains when its result has room or it makes none
    assign move     = full_reg && (!has_result || out_free);
    assign in_stall = full_reg && !move;
    assign accept   = in_valid && !in_stall;
    assign full_next = accept || (full_reg && !move);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
            last_reg <= last_of_buffer;
        end
    end

    dsd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dsd_decoder #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (move),
        .in_byte    (byte_reg),
        .last       (last_reg),
        .cfg        (cfg),
        .has_result (has_result),
        .res        (res)
    );

    dsd_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (move && has_result),
        .res          (res),
        .out_stall    (out_stall),
        .free         (out_free),
        .out_valid    (out_valid),
        .result_kind  (result_kind),
        .payload_byte (payload_byte),
        .byte_count   (byte_count)
    );

endmodule

/* rtl/dsd_checker.sv */
// ----------------------------------------------------------------------------
// dsd_checker
// port-level checks of the deframer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  result_kind,
    input logic [7:0]  payload_byte,
    input logic [15:0] byte_count
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "out valid dropped")
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(result_kind) && $stable(payload_byte) && $stable(byte_count), "stalled result changed")
    `ASSERT_IMPL(a_payload_count, clk, rst_n, out_valid && result_kind == dsd_pkg::KIND_PAYLOAD, byte_count != 16'd0, "payload transfer with zero count")
    `ASSERT_IMPL(a_nonpayload_byte, clk, rst_n, out_valid && result_kind != dsd_pkg::KIND_PAYLOAD, payload_byte == 8'd0, "status transfer carries a byte")

endmodule

bind dle_stuffing_deframer dsd_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .payload_byte (payload_byte),
    .byte_count   (byte_count)
);
